@@ hdl/i2b26_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package i2b26_pkg;

	// Field widths
	localparam int ValW      = 64;
	localparam int CharW     = 8;
	localparam int LenW      = 6;
	localparam int MinDigW   = 6;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 8;

	// Conversion constants
	localparam int DigitBase    = 26;
	localparam int DigitW       = 5;
	localparam int ChunkW       = 8;
	localparam int NumChunks    = ValW / ChunkW;
	localparam int ChunkCntW    = $clog2(NumChunks);
	// 26^14 exceeds 2^64, so a 64-bit magnitude never needs more digits
	localparam int MaxValDigits = 14;
	localparam int DigCntW      = $clog2(MaxValDigits + 1);
	localparam int MaxDigitsDef = 32;
	localparam logic [CharW-1:0] MinusChar = 8'd45;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_ALPHABET_BASE = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MIN_DIGITS    = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_OUT_LIMIT     = 2'd2;

	typedef logic [DigitW-1:0] digit_t;

endpackage
`default_nettype wire

@@ hdl/i2b26_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input item: value and its signedness selector
interface i2b26_in_if import i2b26_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            func;
	logic [ValW-1:0] value;
	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

// Result item: one text character
interface i2b26_out_if import i2b26_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CharW-1:0] char_code;
	logic             last;
	logic [LenW-1:0]  text_length;
	logic             overflow;
	modport source (output valid, output char_code, output last, output text_length,
		output overflow, input ready);
	modport sink (input valid, input char_code, input last, input text_length,
		input overflow, output ready);
endinterface

// Register write channel
interface i2b26_cfg_if import i2b26_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/int_to_base26_text_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Integer to base-26 letter text converter.
// in_item  : one 64-bit value per transaction, func selects unsigned (0) or signed (1).
// out_item : one character per transaction, most significant first; the final one
//            carries last and the total text_length. When the text would not fit in
//            out_limit a single transaction with overflow set is sent instead.
// cfg      : register writes (alphabet_base, min_digits, out_limit), always ready;
//            write only while no conversion is in progress.
// Operation: one shared 8-bit long-division step unit divides the magnitude by 26,
// one byte per cycle, yielding one digit per pass over the magnitude. The ST_LEN
// state then sizes the text, and characters leave at one per cycle from the output
// register while the receiver accepts them. in_item is ready from the cycle after
// the last character, or the single overflow transaction, is loaded, so no new value
// is taken while a conversion is in progress. If the receiver stalls, the character
// in the output register holds and the sequencer waits. Reset clears the sequencer
// and output valid and puts the registers at alphabet_base 97, min_digits 0,
// out_limit 63.
module int_to_base26_text_unit import i2b26_pkg::*; #(
	parameter int MAX_DIGITS = MaxDigitsDef
) (
	input  wire           clk,
	input  wire           arst_n,
	i2b26_in_if.sink      in_item,
	i2b26_out_if.source   out_item,
	i2b26_cfg_if.sink     cfg
);

	localparam int CntW = $clog2(MAX_DIGITS + 2);
	localparam int CmpW = (CntW > MinDigW + 1) ? CntW + 1 : MinDigW + 2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_LEN  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]           state_q;
	logic [CharW-1:0]     alpha_q;
	logic [MinDigW-1:0]   min_dig_q;
	logic [LenW-1:0]      limit_q;

	logic [ValW-1:0]      mag_q;
	logic [DigitW-1:0]    rem_q;
	logic [ChunkCntW-1:0] chunk_q;
	logic                 neg_q;
	logic                 ovf_q;
	logic [DigCntW-1:0]   ndig_q;
	logic [CntW-1:0]      pad_q;
	logic [CntW-1:0]      left_q;
	logic [CntW-1:0]      total_q;
	digit_t               stack_q [MaxValDigits];

	logic                 out_valid_q;
	logic [CharW-1:0]     out_char_q;
	logic                 out_last_q;
	logic [LenW-1:0]      out_len_q;
	logic                 out_ovf_q;

	logic                 in_acc;
	logic                 out_load;
	logic                 pop;
	logic [ChunkW-1:0]    qbyte;
	logic [DigitW-1:0]    rem_d;
	logic [ValW-1:0]      mag_d;
	logic                 in_neg;
	logic [CntW-1:0]      min_clamp;
	logic [CntW-1:0]      width;
	logic [CntW-1:0]      total;
	logic                 too_long;

	assign in_item.ready = (state_q == ST_IDLE);
	assign in_acc        = in_item.valid && in_item.ready;
	assign cfg.ready     = 1'b1;
	assign in_neg        = in_item.func && in_item.value[ValW-1];

	// Long-division step unit: feed one dividend byte through eight restoring steps
	always_comb begin
		logic [DigitW:0] t;
		int i;
		rem_d = rem_q;
		qbyte = '0;
		for (i = ChunkW - 1; i >= 0; i--) begin
			t = {rem_d, mag_q[ValW-ChunkW+i]};
			if (t >= (DigitW+1)'(DigitBase)) begin
				qbyte[i] = 1'b1;
				rem_d    = DigitW'(t - (DigitW+1)'(DigitBase));
			end else begin
				rem_d = t[DigitW-1:0];
			end
		end
		mag_d = {mag_q[ValW-ChunkW-1:0], qbyte};
	end

	// Size the text: clamped minimum, digit count, sign
	always_comb begin
		if (CmpW'(min_dig_q) > CmpW'(MAX_DIGITS)) begin
			min_clamp = CntW'(MAX_DIGITS);
		end else begin
			min_clamp = CntW'(min_dig_q);
		end
		if (min_clamp < CntW'(ndig_q)) begin
			width = CntW'(ndig_q);
		end else begin
			width = min_clamp;
		end
		total    = width + CntW'(neg_q);
		too_long = CmpW'(total) > CmpW'(limit_q);
	end

	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_item.ready);
	assign pop      = out_load && !ovf_q && !neg_q && (pad_q == '0);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= 8'd97;
			min_dig_q <= '0;
			limit_q   <= 6'd63;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ALPHABET_BASE: alpha_q   <= cfg.data;
				REG_MIN_DIGITS:    min_dig_q <= cfg.data[MinDigW-1:0];
				REG_OUT_LIMIT:     limit_q   <= cfg.data[LenW-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chunk_q <= '0;
			ndig_q  <= '0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			pad_q   <= '0;
			left_q  <= '0;
			total_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						neg_q   <= in_neg;
						chunk_q <= '0;
						ndig_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					chunk_q <= chunk_q + 1'b1;
					if (chunk_q == ChunkCntW'(NumChunks - 1)) begin
						ndig_q <= ndig_q + 1'b1;
						if (mag_d == '0) begin
							state_q <= ST_LEN;
						end
					end
				end
				ST_LEN: begin
					ovf_q   <= too_long;
					pad_q   <= width - CntW'(ndig_q);
					left_q  <= total;
					total_q <= total;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						priority if (ovf_q) begin
							ovf_q   <= 1'b0;
							neg_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else if (neg_q) begin
							neg_q <= 1'b0;
						end else if (pad_q != '0) begin
							pad_q <= pad_q - 1'b1;
						end else begin
							// digits: the stack advances on pop
						end
						if (!ovf_q) begin
							left_q <= left_q - 1'b1;
							if (left_q == CntW'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Dividend, remainder and digit stack (payload)
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q <= in_neg ? (ValW'(0) - in_item.value) : in_item.value;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			mag_q <= mag_d;
			if (chunk_q == ChunkCntW'(NumChunks - 1)) begin
				rem_q      <= '0;
				stack_q[0] <= rem_d;
				for (int i = 1; i < MaxValDigits; i++) begin
					stack_q[i] <= stack_q[i-1];
				end
			end else begin
				rem_q <= rem_d;
			end
		end else if (pop) begin
			for (int i = 0; i < MaxValDigits - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload: overflow marker, or sign, padding, then digits
	always_ff @(posedge clk) begin
		if (out_load) begin
			priority if (ovf_q) begin
				out_char_q <= '0;
				out_last_q <= 1'b1;
				out_len_q  <= '0;
				out_ovf_q  <= 1'b1;
			end else begin
				if (neg_q) begin
					out_char_q <= MinusChar;
				end else if (pad_q != '0) begin
					out_char_q <= alpha_q;
				end else begin
					out_char_q <= alpha_q + CharW'(stack_q[0]);
				end
				out_last_q <= (left_q == CntW'(1));
				out_len_q  <= (left_q == CntW'(1)) ? LenW'(total_q) : '0;
				out_ovf_q  <= 1'b0;
			end
		end
	end

	assign out_item.valid       = out_valid_q;
	assign out_item.char_code   = out_char_q;
	assign out_item.last        = out_last_q;
	assign out_item.text_length = out_len_q;
	assign out_item.overflow    = out_ovf_q;

endmodule
`default_nettype wire
